// ===== rtl/core/tsc_pkg.sv =====
// Package for the token scanner: token kind codes, run and keyword codes,
// caps on length and offset, result queue sizing and the result record type.
// No dependencies.
`timescale 1ns / 1ps

package tsc_pkg;

  // Caps on token length and byte offset.
  localparam int unsigned MaxTokenLen  = 255;
  localparam int unsigned MaxSourceLen = 65536;
  localparam logic [7:0]  LEN_CAP = (MaxTokenLen < 255) ? 8'(MaxTokenLen) : 8'd255;
  localparam logic [15:0] POS_CAP = ((MaxSourceLen - 1) < 65535) ?
                                    16'(MaxSourceLen - 1) : 16'd65535;

  // Result queue: one item may produce two results.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [2:0] {
    KIND_NUMBER = 3'd0,
    KIND_IDENT  = 3'd1,
    KIND_LET    = 3'd2,
    KIND_EQUALS = 3'd3,
    KIND_PLUS   = 3'd4,
    KIND_SEMI   = 3'd5,
    KIND_END    = 3'd6
  } kind_e;

  // Open run.
  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_NUM   = 2'd1;
  localparam logic [1:0] MODE_IDENT = 2'd2;

  // Keyword match progress toward "let".
  localparam logic [2:0] KW_NONE = 3'd0;
  localparam logic [2:0] KW_L    = 3'd1;
  localparam logic [2:0] KW_LE   = 3'd2;
  localparam logic [2:0] KW_LET  = 3'd3;
  localparam logic [2:0] KW_MISS = 3'd4;

  localparam logic [7:0] CHAR_END   = 8'h00;
  localparam logic [7:0] CHAR_EQ    = 8'h3d;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_SEMI  = 8'h3b;
  localparam logic [7:0] CHAR_LOW_L = 8'h6c;
  localparam logic [7:0] CHAR_LOW_E = 8'h65;
  localparam logic [7:0] CHAR_LOW_T = 8'h74;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] start;
    logic [7:0]  len;
    logic        sat;
    logic        last;
  } result_t;

endpackage

// ===== rtl/core/token_scanner_core.sv =====
// Token scanner top level: byte-serial lexer with a small result queue.
// Depends on tsc_pkg.
`timescale 1ns / 1ps

//  channel | direction | handshake               | payload
//  input   | in        | in_valid_i / in_stall_o | character_i
//  output  | out       | out_valid_o / out_stall_i | token_kind_o, start_offset_o,
//          |           |                         | token_length_o, length_saturated_o,
//          |           |                         | last_of_run_o
//
// One byte is accepted per cycle unless stalled; its results enter a four-entry
// queue in the same edge; if it was empty, the first one is visible on the next
// cycle. A byte yields zero, one or two results; the queue drains one per cycle
// unless stalled, so sustained rate is one byte per cycle unless bytes produce
// two results. in_stall_o rises while fewer than two queue entries are free.
// Reset clears the scanner state and empties the queue; no clearing pass.
module token_scanner_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  character_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  token_kind_o,
  output logic [15:0] start_offset_o,
  output logic [7:0]  token_length_o,
  output logic        length_saturated_o,
  output logic        last_of_run_o
);

  logic [1:0]  run_mode_q, run_mode_d;
  logic [2:0]  kw_prog_q, kw_prog_d;
  logic [15:0] run_start_q, run_start_d;
  logic [7:0]  run_len_q, run_len_d;
  logic        run_ovf_q, run_ovf_d;
  logic [15:0] byte_pos_q, byte_pos_d;

  tsc_pkg::result_t res0, res1;
  logic [1:0]       res_n;

  logic [tsc_pkg::FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [tsc_pkg::FIFO_AW:0]   cnt_q;
  tsc_pkg::result_t            fifo_mem [tsc_pkg::FIFO_DEPTH];

  logic in_acc, out_acc;
  logic is_digit, is_letter, extend;
  logic [2:0] kw_step;

  assign in_stall_o = (cnt_q > (tsc_pkg::FIFO_AW+1)'(tsc_pkg::FIFO_DEPTH - 2));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_acc    = out_valid_o && !out_stall_i;

  assign is_digit  = (character_i >= 8'h30) && (character_i <= 8'h39);
  assign is_letter = ((character_i >= 8'h61) && (character_i <= 8'h7a)) ||
                     ((character_i >= 8'h41) && (character_i <= 8'h5a));

  always_comb begin
    kw_step = tsc_pkg::KW_MISS;
    if (kw_prog_q == tsc_pkg::KW_NONE && character_i == tsc_pkg::CHAR_LOW_L) begin
      kw_step = tsc_pkg::KW_L;
    end else if (kw_prog_q == tsc_pkg::KW_L && character_i == tsc_pkg::CHAR_LOW_E) begin
      kw_step = tsc_pkg::KW_LE;
    end else if (kw_prog_q == tsc_pkg::KW_LE && character_i == tsc_pkg::CHAR_LOW_T) begin
      kw_step = tsc_pkg::KW_LET;
    end
  end

  always_comb begin
    run_mode_d  = run_mode_q;
    kw_prog_d   = kw_prog_q;
    run_start_d = run_start_q;
    run_len_d   = run_len_q;
    run_ovf_d   = run_ovf_q;
    byte_pos_d  = byte_pos_q;
    res0  = '{kind: tsc_pkg::KIND_NUMBER, start: run_start_q, len: run_len_q,
              sat: run_ovf_q, last: 1'b0};
    res1  = '{kind: tsc_pkg::KIND_END, start: byte_pos_q, len: 8'd0,
              sat: 1'b0, last: 1'b1};
    res_n = 2'd0;
    extend = (run_mode_q == tsc_pkg::MODE_NUM && is_digit) ||
             (run_mode_q == tsc_pkg::MODE_IDENT && (is_digit || is_letter));

    if (in_acc) begin
      if (byte_pos_q < tsc_pkg::POS_CAP) begin
        byte_pos_d = byte_pos_q + 16'd1;
      end
      if (extend) begin
        if (run_mode_q == tsc_pkg::MODE_IDENT) begin
          kw_prog_d = kw_step;
        end
        if (run_len_q < tsc_pkg::LEN_CAP) begin
          run_len_d = run_len_q + 8'd1;
        end else begin
          run_ovf_d = 1'b1;
        end
      end else begin
        // Close any open run, then look at the byte on its own.
        if (run_mode_q != tsc_pkg::MODE_NONE) begin
          res_n = 2'd1;
          if (run_mode_q == tsc_pkg::MODE_IDENT) begin
            res0.kind = (kw_prog_q == tsc_pkg::KW_LET) ? tsc_pkg::KIND_LET
                                                       : tsc_pkg::KIND_IDENT;
          end
        end
        run_mode_d  = tsc_pkg::MODE_NONE;
        kw_prog_d   = tsc_pkg::KW_NONE;
        run_start_d = '0;
        run_len_d   = '0;
        run_ovf_d   = 1'b0;

        if (character_i == tsc_pkg::CHAR_END) begin
          res_n      = res_n + 2'd1;
          byte_pos_d = '0;
        end else if (character_i == tsc_pkg::CHAR_EQ ||
                     character_i == tsc_pkg::CHAR_PLUS ||
                     character_i == tsc_pkg::CHAR_SEMI) begin
          res_n     = res_n + 2'd1;
          res1.len  = 8'd1;
          res1.kind = (character_i == tsc_pkg::CHAR_EQ)   ? tsc_pkg::KIND_EQUALS :
                      (character_i == tsc_pkg::CHAR_PLUS) ? tsc_pkg::KIND_PLUS
                                                          : tsc_pkg::KIND_SEMI;
        end else if (is_digit || is_letter) begin
          run_mode_d  = is_digit ? tsc_pkg::MODE_NUM : tsc_pkg::MODE_IDENT;
          run_start_d = byte_pos_q;
          run_len_d   = 8'd1;
          kw_prog_d   = (is_letter && character_i == tsc_pkg::CHAR_LOW_L) ?
                        tsc_pkg::KW_L : tsc_pkg::KW_MISS;
        end

        // A lone symbol or end token goes out as the only result.
        if (run_mode_q == tsc_pkg::MODE_NONE) begin
          res0 = res1;
        end else if (res_n == 2'd1) begin
          res0.last = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_mode_q  <= tsc_pkg::MODE_NONE;
      kw_prog_q   <= tsc_pkg::KW_NONE;
      run_start_q <= '0;
      run_len_q   <= '0;
      run_ovf_q   <= 1'b0;
      byte_pos_q  <= '0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      cnt_q       <= '0;
    end else begin
      run_mode_q  <= run_mode_d;
      kw_prog_q   <= kw_prog_d;
      run_start_q <= run_start_d;
      run_len_q   <= run_len_d;
      run_ovf_q   <= run_ovf_d;
      byte_pos_q  <= byte_pos_d;
      wr_ptr_q    <= wr_ptr_q + tsc_pkg::FIFO_AW'(res_n);
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + tsc_pkg::FIFO_AW'(1);
      end
      cnt_q <= cnt_q + (tsc_pkg::FIFO_AW+1)'(res_n) -
               (tsc_pkg::FIFO_AW+1)'(out_acc);
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_n != 2'd0) begin
      fifo_mem[wr_ptr_q] <= res0;
    end
    if (res_n == 2'd2) begin
      fifo_mem[wr_ptr_q + tsc_pkg::FIFO_AW'(1)] <= res1;
    end
  end

  assign token_kind_o       = fifo_mem[rd_ptr_q].kind;
  assign start_offset_o     = fifo_mem[rd_ptr_q].start;
  assign token_length_o     = fifo_mem[rd_ptr_q].len;
  assign length_saturated_o = fifo_mem[rd_ptr_q].sat;
  assign last_of_run_o      = fifo_mem[rd_ptr_q].last;

endmodule

// ===== rtl/core/tsc_checker.sv =====
// Port-level checks for the token scanner, attached by bind below.
// Depends on tsc_pkg and token_scanner_core.
`timescale 1ns / 1ps

module tsc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  character_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  token_kind_o,
  input logic [15:0] start_offset_o,
  input logic [7:0]  token_length_o,
  input logic        length_saturated_o,
  input logic        last_of_run_o
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(token_kind_o) &&
      $stable(start_offset_o) && $stable(token_length_o) &&
      $stable(length_saturated_o) && $stable(last_of_run_o))
    else $error("stalled result changed");

  // End token: zero length, no saturation, closes its byte.
  a_end_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == tsc_pkg::KIND_END |->
      token_length_o == 8'd0 && !length_saturated_o && last_of_run_o)
    else $error("malformed end token");

  // Symbols are one byte and always the final result of their byte.
  a_sym_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o == tsc_pkg::KIND_EQUALS ||
      token_kind_o == tsc_pkg::KIND_PLUS || token_kind_o == tsc_pkg::KIND_SEMI) |->
      token_length_o == 8'd1 && !length_saturated_o && last_of_run_o)
    else $error("malformed symbol token");

  // A saturated run reports the cap.
  a_sat_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && length_saturated_o |-> token_length_o == tsc_pkg::LEN_CAP)
    else $error("saturated length below cap");

  // A run token that is not last is followed by the symbol or end of the same byte.
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_run_o |=>
      out_valid_o && token_kind_o != tsc_pkg::KIND_NUMBER &&
      token_kind_o != tsc_pkg::KIND_IDENT && token_kind_o != tsc_pkg::KIND_LET)
    else $error("second result of a byte missing");

endmodule

bind token_scanner_core tsc_checker u_tsc_checker (.*);

// ===== verif/testbench.sv =====
// Testbench for token_scanner_core. It sends random source text and checks each token
// (kind, offset, length, saturation, last) against a scanner model kept in the bench.
// Depends on tsc_pkg and the token_scanner_core RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned IDLE_PCT    = 29;
  localparam int unsigned HOLD_START  = 800;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned QUIET_FROM  = 1500;
  localparam int unsigned QUIET_TO    = 2200;
  localparam int unsigned MAX_REPORTS = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  character_i = 8'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  token_kind_o;
  logic [15:0] start_offset_o;
  logic [7:0]  token_length_o;
  logic        length_saturated_o;
  logic        last_of_run_o;

  token_scanner_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .character_i        (character_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .token_kind_o       (token_kind_o),
    .start_offset_o     (start_offset_o),
    .token_length_o     (token_length_o),
    .length_saturated_o (length_saturated_o),
    .last_of_run_o      (last_of_run_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic [7:0]        src_bytes[$];
  tsc_pkg::result_t  expected_tokens[$];
  int unsigned cycle_cnt = 0;
  int unsigned hold_left = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned tokens_checked = 0;
  int unsigned bytes_taken = 0;
  int unsigned bytes_offered = 0;
  int unsigned sources_sent = 0;
  int unsigned capped_tokens = 0;
  logic        quiet_window;

  assign quiet_window = (cycle_cnt >= QUIET_FROM) && (cycle_cnt < QUIET_TO);

  // Scanner state as the block should hold it.
  logic [1:0]  scan_mode = tsc_pkg::MODE_NONE;
  logic [2:0]  kw_state = tsc_pkg::KW_NONE;
  logic [15:0] tok_start = '0;
  logic [7:0]  tok_len = '0;
  logic        tok_over = 1'b0;
  logic [15:0] src_pos = '0;

  function automatic logic is_numeral(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [2:0] kw_advance(logic [2:0] prog, logic [7:0] c);
    if (prog == tsc_pkg::KW_NONE && c == tsc_pkg::CHAR_LOW_L) return tsc_pkg::KW_L;
    if (prog == tsc_pkg::KW_L && c == tsc_pkg::CHAR_LOW_E) return tsc_pkg::KW_LE;
    if (prog == tsc_pkg::KW_LE && c == tsc_pkg::CHAR_LOW_T) return tsc_pkg::KW_LET;
    return tsc_pkg::KW_MISS;
  endfunction

  function automatic tsc_pkg::result_t make_token(tsc_pkg::kind_e k, logic [15:0] s,
                                                  logic [7:0] l, logic o);
    tsc_pkg::result_t t;
    t.kind = k;
    t.start = s;
    t.len = l;
    t.sat = o;
    t.last = 1'b0;
    return t;
  endfunction

  task automatic add_byte(input logic [7:0] b);
    src_bytes = {src_bytes, b};
  endtask

  // Advance the scanner by one byte and queue the tokens it closes or emits.
  task automatic scan_byte(input logic [7:0] c);
    tsc_pkg::result_t found[$];
    logic [15:0]      here;
    logic             grows;
    here = src_pos;
    grows = 1'b0;
    if (scan_mode == tsc_pkg::MODE_NUM) begin
      if (is_numeral(c)) grows = 1'b1;
      else found = {found, make_token(tsc_pkg::KIND_NUMBER, tok_start, tok_len, tok_over)};
    end else if (scan_mode == tsc_pkg::MODE_IDENT) begin
      if (is_numeral(c) || is_alpha(c)) begin
        kw_state = kw_advance(kw_state, c);
        grows = 1'b1;
      end else begin
        found = {found, make_token((kw_state == tsc_pkg::KW_LET) ? tsc_pkg::KIND_LET
                                                                : tsc_pkg::KIND_IDENT,
                                   tok_start, tok_len, tok_over)};
      end
    end
    if (grows) begin
      if (tok_len < tsc_pkg::LEN_CAP) tok_len++;
      else tok_over = 1'b1;
    end else begin
      if (found.size() != 0 && tok_over) capped_tokens++;
      scan_mode = tsc_pkg::MODE_NONE;
      kw_state = tsc_pkg::KW_NONE;
      tok_start = '0;
      tok_len = '0;
      tok_over = 1'b0;
      if (c == tsc_pkg::CHAR_END) begin
        found = {found, make_token(tsc_pkg::KIND_END, here, 8'd0, 1'b0)};
      end else if (c == tsc_pkg::CHAR_EQ) begin
        found = {found, make_token(tsc_pkg::KIND_EQUALS, here, 8'd1, 1'b0)};
      end else if (c == tsc_pkg::CHAR_PLUS) begin
        found = {found, make_token(tsc_pkg::KIND_PLUS, here, 8'd1, 1'b0)};
      end else if (c == tsc_pkg::CHAR_SEMI) begin
        found = {found, make_token(tsc_pkg::KIND_SEMI, here, 8'd1, 1'b0)};
      end else if (is_numeral(c)) begin
        scan_mode = tsc_pkg::MODE_NUM;
        tok_start = here;
        tok_len = 8'd1;
      end else if (is_alpha(c)) begin
        scan_mode = tsc_pkg::MODE_IDENT;
        tok_start = here;
        tok_len = 8'd1;
        kw_state = kw_advance(tsc_pkg::KW_NONE, c);
      end
    end
    // The end byte clears the offset for the next source.
    if (c == tsc_pkg::CHAR_END) src_pos = '0;
    else if (src_pos < tsc_pkg::POS_CAP) src_pos++;
    if (found.size() != 0) found[found.size() - 1].last = 1'b1;
    expected_tokens = {expected_tokens, found};
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (mismatch_cnt < MAX_REPORTS)
      $display("mismatch at token %0d: %s got %0d want %0d", tokens_checked, what, got, want);
    mismatch_cnt++;
  endtask

  // Check delivered tokens, then track accepted bytes.
  always @(posedge clk_i) begin : monitor
    tsc_pkg::result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch("token with none expected, kind", 16'(token_kind_o), 16'd0);
        end else begin
          want = expected_tokens.pop_front();
          if (token_kind_o !== want.kind)
            report_mismatch("kind", 16'(token_kind_o), 16'(want.kind));
          if (start_offset_o !== want.start)
            report_mismatch("start offset", start_offset_o, want.start);
          if (token_length_o !== want.len)
            report_mismatch("length", 16'(token_length_o), 16'(want.len));
          if (length_saturated_o !== want.sat)
            report_mismatch("saturated flag", 16'(length_saturated_o), 16'(want.sat));
          if (last_of_run_o !== want.last)
            report_mismatch("last flag", 16'(last_of_run_o), 16'(want.last));
          tokens_checked++;
        end
      end
      if (in_valid_i && !in_stall_o) begin
        scan_byte(character_i);
        bytes_taken++;
      end
    end
  end

  // Offer the next byte once the current one is taken; idle at random.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || bytes_taken == bytes_offered)) begin
      if (src_bytes.size() != 0 &&
          (quiet_window || hold_left != 0 || $urandom_range(99) >= IDLE_PCT)) begin
        in_valid_i <= 1'b1;
        character_i <= src_bytes.pop_front();
        bytes_offered++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Long receiver hold-off so the result queue fills and the input stalls.
  always @(negedge clk_i) begin
    if (cycle_cnt == HOLD_START) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(negedge clk_i) begin
    out_stall_i <= (hold_left != 0) || (!quiet_window && $urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d tokens outstanding", cycle_cnt,
               expected_tokens.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(1) == 0) return 8'("a" + $urandom_range(25));
    return 8'("A" + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(9));
  endfunction

  // Whitespace or a byte the scanner skips; never the end byte.
  function automatic logic [7:0] filler_byte();
    case ($urandom_range(6))
      0, 1:    return 8'd32;
      2:       return 8'($urandom_range(13, 9));
      3:       return 8'($urandom_range(255, 128));
      4:       return 8'($urandom_range(8, 1));
      5:       return ($urandom_range(1) == 0) ? 8'd127 : 8'($urandom_range(31, 14));
      default: begin
        case ($urandom_range(5))
          0:       return 8'($urandom_range(42, 33));
          1:       return 8'($urandom_range(47, 44));
          2:       return 8'd58;
          3:       return ($urandom_range(1) == 0) ? 8'd60 : 8'($urandom_range(64, 62));
          4:       return 8'($urandom_range(96, 91));
          default: return 8'($urandom_range(126, 123));
        endcase
      end
    endcase
  endfunction

  task automatic push_word();
    int n;
    int i;
    case ($urandom_range(10))
      0, 1: begin
        n = $urandom_range(6, 1);
        for (i = 0; i < n; i++) add_byte(rand_digit());
      end
      2: push_text("let");
      3: begin
        case ($urandom_range(6))
          0:       push_text("le");
          1:       push_text("l");
          2:       push_text("lets");
          3:       push_text("Let");
          4:       push_text("lEt");
          5:       push_text("let7");
          default: push_text("xlet");
        endcase
      end
      4, 5: begin
        n = $urandom_range(7);
        add_byte(rand_letter());
        for (i = 0; i < n; i++)
          add_byte(($urandom_range(2) == 0) ? rand_digit() : rand_letter());
      end
      6: add_byte(tsc_pkg::CHAR_EQ);
      7: add_byte(tsc_pkg::CHAR_PLUS);
      8: add_byte(tsc_pkg::CHAR_SEMI);
      9: add_byte(filler_byte());
      // Raw noise, the end byte included.
      default: add_byte(8'($urandom_range(255)));
    endcase
  endtask

  // Runs near and past the length cap.
  task automatic push_long_run();
    int n;
    int i;
    logic digits;
    case ($urandom_range(4))
      0:       n = 254;
      1:       n = 255;
      2:       n = 256;
      3:       n = 257;
      default: n = $urandom_range(600, 258);
    endcase
    digits = 1'($urandom_range(1));
    add_byte(digits ? rand_digit() : rand_letter());
    for (i = 1; i < n; i++)
      add_byte((digits || $urandom_range(3) == 0) ? rand_digit() : rand_letter());
  endtask

  task automatic add_source();
    int words;
    int w;
    int gap;
    words = $urandom_range(12, 1);
    for (w = 0; w < words; w++) begin
      if ($urandom_range(24) == 0) push_long_run();
      else push_word();
      if ($urandom_range(9) >= 6) begin
        gap = $urandom_range(3, 1);
        repeat (gap) add_byte(filler_byte());
      end
    end
    // Mostly close the source; otherwise the next one runs on from here.
    if ($urandom_range(9) != 0) begin
      add_byte(tsc_pkg::CHAR_END);
      sources_sent++;
    end
  endtask

  initial begin
    // Keyword, near keyword, symbols, digit and letter edges, skipped bytes,
    // a run closed by the end byte and an end byte on its own.
    push_text("let lets=9+Az;");
    add_byte(8'hff);
    add_byte(8'h80);
    add_byte(8'h09);
    add_byte(8'h0d);
    push_text("0");
    add_byte(tsc_pkg::CHAR_END);
    add_byte(tsc_pkg::CHAR_END);
    sources_sent += 2;

    while (src_bytes.size() < 1690) add_source();
    add_byte(tsc_pkg::CHAR_END);
    sources_sent++;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (src_bytes.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_tokens.size() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("scanned %0d bytes over %0d sources; %0d tokens checked", bytes_taken,
             sources_sent, tokens_checked);
    $display("%0d tokens hit the length cap", capped_tokens);
    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/tsc_pkg.sv
rtl/core/token_scanner_core.sv
rtl/core/tsc_checker.sv
verif/testbench.sv
